// ===== rtl/c2ab_pkg.sv =====
// c2ab_pkg: types, op codes, queue sizes and the saturating add shared by the
// CIGAR-to-aligned-blocks modules. No dependencies.
package c2ab_pkg;

	// CIGAR op codes
	localparam logic [3:0] OP_M  = 4'd0;
	localparam logic [3:0] OP_I  = 4'd1;
	localparam logic [3:0] OP_D  = 4'd2;
	localparam logic [3:0] OP_N  = 4'd3;
	localparam logic [3:0] OP_S  = 4'd4;
	localparam logic [3:0] OP_H  = 4'd5;
	localparam logic [3:0] OP_P  = 4'd6;
	localparam logic [3:0] OP_EQ = 4'd7;
	localparam logic [3:0] OP_X  = 4'd8;

	// op queue (front) and result queue (back) sizes
	localparam int OPQ_DEPTH = 4;
	localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
	localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);
	localparam int RQ_DEPTH  = 4;
	localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W  = $clog2(RQ_DEPTH + 1);

	typedef struct packed {
		logic [3:0]  op_kind;
		logic [27:0] op_length;
		logic [30:0] read_position;
		logic        reverse_flag;
		logic        final_op;
	} op_item_t;

	typedef struct packed {
		logic [31:0] block_offset;
		logic [31:0] block_length;
		logic        last_block;
		logic [31:0] read_end;
		logic [31:0] aligned_total;
		logic        forward_strand;
	} block_t;

	// what an op does to the block state
	typedef enum logic [2:0] {
		CLS_EXTEND = 3'b001,
		CLS_SKIP   = 3'b010,
		CLS_IGNORE = 3'b100
	} op_cls_t;

	typedef struct packed {
		op_cls_t     cls;
		logic [27:0] op_length;
		logic [30:0] read_position;
		logic        reverse_flag;
		logic        final_op;
	} cls_item_t;

	// up to two results written into the result queue per cycle
	typedef struct packed {
		logic [1:0] n;
		block_t     a;
		block_t     b;
	} res_wr_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

// ===== rtl/c2ab_front.sv =====
// c2ab_front: accepts CIGAR ops, decodes them into an op class and holds them
// in a short queue for the back end. Depends on c2ab_pkg.
module c2ab_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  c2ab_pkg::op_item_t   op,
	input  logic                 deq,
	output logic                 item_valid,
	output c2ab_pkg::cls_item_t  item
);

	c2ab_pkg::cls_item_t                 mem_q [c2ab_pkg::OPQ_DEPTH];
	logic [c2ab_pkg::OPQ_PTR_W-1:0]      wptr_q, rptr_q;
	logic [c2ab_pkg::OPQ_CNT_W-1:0]      cnt_q;
	c2ab_pkg::op_cls_t                   cls;
	c2ab_pkg::cls_item_t                 wdata;
	logic                                wr, rd;

	always_comb begin
		unique case (op.op_kind) inside
			c2ab_pkg::OP_M, c2ab_pkg::OP_D, c2ab_pkg::OP_EQ, c2ab_pkg::OP_X: cls = c2ab_pkg::CLS_EXTEND;
			c2ab_pkg::OP_N: cls = c2ab_pkg::CLS_SKIP;
			default:        cls = c2ab_pkg::CLS_IGNORE;  // I, S, H, P and unused codes
		endcase
	end

	assign wdata.cls           = cls;
	assign wdata.op_length     = op.op_length;
	assign wdata.read_position = op.read_position;
	assign wdata.reverse_flag  = op.reverse_flag;
	assign wdata.final_op      = op.final_op;

	assign full       = (cnt_q == c2ab_pkg::OPQ_CNT_W'(c2ab_pkg::OPQ_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign wr         = push & ~full;
	assign rd         = deq & item_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (wr && (cnt_q == '0 || (rd && cnt_q == c2ab_pkg::OPQ_CNT_W'(1)))) begin
			item <= wdata;
		end else begin
			item <= mem_q[rd ? rptr_q + 1'b1 : rptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + 1'b1;
			if (rd) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + c2ab_pkg::OPQ_CNT_W'(wr) - c2ab_pkg::OPQ_CNT_W'(rd);
		end
	end

endmodule

// ===== rtl/c2ab_back.sv =====
// c2ab_back: block state machine. One classified op per cycle unless s1 is
// held; updates open block, emits up to two blocks per op. Uses c2ab_pkg.
module c2ab_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  c2ab_pkg::cls_item_t  item,
	output logic                 take,
	input  logic                 room,
	output c2ab_pkg::res_wr_t    wr
);

	logic        inside_q;
	logic [31:0] span_q, start_q, open_len_q, sum_q;
	logic        inside_n;
	logic [31:0] span_n, start_n, open_len_n, sum_n;
	logic [31:0] len32, span_add;
	logic        close_v;
	c2ab_pkg::block_t  close_blk, last_blk;

	logic              s1_v;
	c2ab_pkg::res_wr_t wr_s1;
	logic [30:0]       pos_s1;
	logic [31:0]       span_s1;
	logic              adv;
	logic [31:0]       read_end;
	logic [1:0]        n_res;

	assign len32    = {4'b0, item.op_length};
	assign span_add = c2ab_pkg::sat_add(span_q, len32);

	always_comb begin
		inside_n   = inside_q;
		span_n     = span_q;
		start_n    = start_q;
		open_len_n = open_len_q;
		sum_n      = sum_q;
		close_v    = 1'b0;
		unique case (item.cls)
			c2ab_pkg::CLS_EXTEND: begin
				open_len_n = inside_q ? c2ab_pkg::sat_add(open_len_q, len32) : len32;
				inside_n   = 1'b1;
				span_n     = span_add;
				sum_n      = c2ab_pkg::sat_add(sum_q, len32);
			end
			c2ab_pkg::CLS_SKIP: begin
				span_n  = span_add;
				start_n = span_add;
				if (inside_q) begin
					close_v    = 1'b1;
					open_len_n = '0;
					inside_n   = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		close_blk                = '0;
		close_blk.block_offset   = start_q;
		close_blk.block_length   = open_len_q;
		last_blk                 = '0;
		last_blk.block_offset    = start_n;
		last_blk.block_length    = open_len_n;
		last_blk.last_block      = 1'b1;
		last_blk.aligned_total   = sum_n;
		last_blk.forward_strand  = ~item.reverse_flag;
	end

	assign n_res = {1'b0, close_v} + {1'b0, item.final_op};
	assign adv   = s1_v & room;
	assign take  = item_valid & (~s1_v | adv);

	// s1: results waiting for the read end add and the result queue
	always_ff @(posedge clk) begin
		if (take) begin
			wr_s1.n <= n_res;
			wr_s1.a <= close_v ? close_blk : last_blk;
			wr_s1.b <= last_blk;
			pos_s1  <= item.read_position;
			span_s1 <= span_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v       <= 1'b0;
			inside_q   <= 1'b1;
			span_q     <= '0;
			start_q    <= '0;
			open_len_q <= '0;
			sum_q      <= '0;
		end else begin
			if (take) begin
				s1_v <= (n_res != 2'd0);
			end else if (adv) begin
				s1_v <= 1'b0;
			end
			if (take) begin
				if (item.final_op) begin
					inside_q   <= 1'b1;
					span_q     <= '0;
					start_q    <= '0;
					open_len_q <= '0;
					sum_q      <= '0;
				end else begin
					inside_q   <= inside_n;
					span_q     <= span_n;
					start_q    <= start_n;
					open_len_q <= open_len_n;
					sum_q      <= sum_n;
				end
			end
		end
	end

	assign read_end = c2ab_pkg::sat_add({1'b0, pos_s1}, span_s1);

	always_comb begin
		wr   = wr_s1;
		wr.n = adv ? wr_s1.n : 2'd0;
		if (wr_s1.a.last_block) wr.a.read_end = read_end;
		if (wr_s1.b.last_block) wr.b.read_end = read_end;
	end

`ifndef SYNTHESIS
	a_s1_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v |-> (wr_s1.n == 2'd1 || wr_s1.n == 2'd2))
		else $error("c2ab_back: s1 holds no result");
	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.final_op) |=> (inside_q && span_q == '0 && sum_q == '0))
		else $error("c2ab_back: state not cleared after final op");
`endif

endmodule

// ===== rtl/c2ab_resq.sv =====
// c2ab_resq: result queue, two write ports, one read port at the head.
// Depends on c2ab_pkg.
module c2ab_resq (
	input  logic               clk,
	input  logic               arst_n,
	input  c2ab_pkg::res_wr_t  wr,
	output logic               room,
	output logic               empty,
	input  logic               pop,
	output c2ab_pkg::block_t   blk
);

	c2ab_pkg::block_t                mem_q [c2ab_pkg::RQ_DEPTH];
	c2ab_pkg::block_t                head_q;
	logic [c2ab_pkg::RQ_PTR_W-1:0]   wptr_q, rptr_q;
	logic [c2ab_pkg::RQ_CNT_W-1:0]   cnt_q;
	logic                            rd;

	assign empty = (cnt_q == '0);
	assign room  = (cnt_q <= c2ab_pkg::RQ_CNT_W'(c2ab_pkg::RQ_DEPTH - 2));
	assign rd    = pop & ~empty;
	assign blk   = head_q;

	always_ff @(posedge clk) begin
		if (wr.n != 2'd0) mem_q[wptr_q] <= wr.a;
		if (wr.n == 2'd2) mem_q[wptr_q + 1'b1] <= wr.b;
	end

	// head register: next stored entry on a pop, the incoming one when nothing
	// else is left
	always_ff @(posedge clk) begin
		if (cnt_q == c2ab_pkg::RQ_CNT_W'(rd)) begin
			head_q <= wr.a;
		end else begin
			head_q <= mem_q[rd ? rptr_q + 1'b1 : rptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + c2ab_pkg::RQ_PTR_W'(wr.n);
			if (rd) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + c2ab_pkg::RQ_CNT_W'(wr.n) - c2ab_pkg::RQ_CNT_W'(rd);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= c2ab_pkg::RQ_CNT_W'(c2ab_pkg::RQ_DEPTH))
		else $error("c2ab_resq: count beyond depth");
	a_write_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.n != 2'd0) |-> room)
		else $error("c2ab_resq: write without room");
	a_summary_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !blk.last_block) |-> (blk.read_end == '0 && blk.aligned_total == '0))
		else $error("c2ab_resq: summary on non-final block");
`endif

endmodule

// ===== rtl/cigar_to_aligned_blocks_top.sv =====
// cigar_to_aligned_blocks_top: top level, CIGAR op stream in, aligned blocks out.
// Depends on c2ab_pkg, c2ab_front, c2ab_back, c2ab_resq.
//
// Splits the reference span of a single-end alignment into aligned blocks.
// One CIGAR op per input transaction (push while full is low); the op marked
// final_op closes the read and produces the last block carrying read_end,
// aligned_total and forward_strand (these three are zero on other blocks).
// M, D, = and X extend the open block; N closes it and opens one after the
// gap, or moves the pending start further out when no block is open; all
// other codes are ignored. Sums saturate at 2^32-1. An op gives zero, one or
// two blocks. Results come out as a queue: the oldest block sits on blk while
// empty is low and leaves on pop. Rate: one op per cycle sustained; the back
// end's result stage moves into the result queue only when two entries are
// free there, so when ops give blocks the pace is set by how fast results are
// popped. On its way to blk an accepted op passes through the op queue's
// output register, then the state update stage, and then, with the read-end
// add, the result queue and its head register. The front op queue holds four
// ops, the result queue four blocks.
module cigar_to_aligned_blocks_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  c2ab_pkg::op_item_t  op,
	output logic                empty,
	input  logic                pop,
	output c2ab_pkg::block_t    blk
);

	logic                 item_valid;
	c2ab_pkg::cls_item_t  item;
	logic                 take;
	logic                 room;
	c2ab_pkg::res_wr_t    wr;

	// front: decode and buffer ops
	c2ab_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.op         (op),
		.deq        (take),
		.item_valid (item_valid),
		.item       (item)
	);

	// back: block state and result build
	c2ab_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.take       (take),
		.room       (room),
		.wr         (wr)
	);

	// result queue toward the consumer
	c2ab_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.room   (room),
		.empty  (empty),
		.pop    (pop),
		.blk    (blk)
	);

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for cigar_to_aligned_blocks_top.
// Depends on c2ab_pkg and the block's RTL; holds its own block predictor and
// a small scoreboard class. Directed CIGAR reads first, then random reads.
module tb_top;

	// op code with no CIGAR meaning, the block must pass over it
	localparam logic [3:0] OP_UNUSED_TOP = 4'd15;
	// read styles for the random part
	localparam int READ_PLAIN = 0;
	localparam int READ_NOISE = 1;
	localparam int READ_HUGE  = 2;
	// random op transactions wanted after the directed part
	localparam int RANDOM_OPS = 800;
	// cycles without any transaction before the run is declared hung
	localparam int QUIET_LIMIT = 2000;
	// settle time at the end: the block's latency plus margin
	localparam int DRAIN_CYCLES = 10;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	c2ab_pkg::op_item_t op;
	logic               empty;
	logic               pop;
	c2ab_pkg::block_t   blk;

	int gap_pct = 16;   // chance per cycle, in percent, that a side idles
	int ops_sent = 0;
	int quiet_cycles = 0;

	// Scoreboard: tracks the read state the same way the block should and
	// keeps the aligned blocks still owed by the block, oldest first.
	class block_scoreboard;
		bit               in_block;
		logic [31:0]      span;
		logic [31:0]      start;
		logic [31:0]      open_len;
		logic [31:0]      total;
		c2ab_pkg::block_t owed[$];
		int               errors;

		function new();
			errors = 0;
			start_read();
		endfunction

		function void start_read();
			in_block = 1'b1;
			span     = '0;
			start    = '0;
			open_len = '0;
			total    = '0;
		endfunction

		// add that sticks at all ones instead of wrapping
		function logic [31:0] clip_add(logic [31:0] a, logic [31:0] b);
			if (a > 32'hFFFF_FFFF - b)
				return 32'hFFFF_FFFF;
			return a + b;
		endfunction

		// append one block to the owed list
		function void owe(c2ab_pkg::block_t b);
			owed.insert(owed.size(), b);
		endfunction

		// one accepted op transaction: update read state, queue what it emits
		function void note_op(c2ab_pkg::op_item_t it);
			logic [31:0]      len;
			c2ab_pkg::block_t b;
			len = {4'd0, it.op_length};
			case (it.op_kind) inside
				c2ab_pkg::OP_M, c2ab_pkg::OP_D, c2ab_pkg::OP_EQ, c2ab_pkg::OP_X: begin
					open_len = in_block ? clip_add(open_len, len) : len;
					in_block = 1'b1;
					span     = clip_add(span, len);
					total    = clip_add(total, len);
				end
				c2ab_pkg::OP_N: begin
					// skip closes an open block; a pending one just moves out
					if (in_block) begin
						b              = '0;
						b.block_offset = start;
						b.block_length = open_len;
						owe(b);
						open_len = '0;
						in_block = 1'b0;
					end
					span  = clip_add(span, len);
					start = span;
				end
				default: begin
				end
			endcase
			if (it.final_op) begin
				b                = '0;
				b.block_offset   = start;
				b.block_length   = open_len;
				b.last_block     = 1'b1;
				b.read_end       = clip_add({1'b0, it.read_position}, span);
				b.aligned_total  = total;
				b.forward_strand = ~it.reverse_flag;
				owe(b);
				start_read();
			end
		endfunction

		function void field_diff(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want,
					got);
			end
		endfunction

		// one accepted result transaction
		function void check_block(c2ab_pkg::block_t got);
			c2ab_pkg::block_t want;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: block with none expected, expected nothing, actual %p",
					$time, got);
				return;
			end
			want = owed.pop_front();
			field_diff("block_offset", want.block_offset, got.block_offset);
			field_diff("block_length", want.block_length, got.block_length);
			field_diff("last_block", 32'(want.last_block), 32'(got.last_block));
			field_diff("read_end", want.read_end, got.read_end);
			field_diff("aligned_total", want.aligned_total, got.aligned_total);
			field_diff("forward_strand", 32'(want.forward_strand), 32'(got.forward_strand));
		endfunction
	endclass

	block_scoreboard blocks = new();

	cigar_to_aligned_blocks_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.op     (op),
		.empty  (empty),
		.pop    (pop),
		.blk    (blk)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: any transaction on either side clears the count. Signals are
	// read right after the edge, so they still hold their pre-edge values.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic c2ab_pkg::op_item_t mk_op(logic [3:0] kind, logic [27:0] len,
			logic [30:0] pos, logic rev, logic fin);
		c2ab_pkg::op_item_t it;
		it.op_kind       = kind;
		it.op_length     = len;
		it.read_position = pos;
		it.reverse_flag  = rev;
		it.final_op      = fin;
		return it;
	endfunction

	function automatic logic [27:0] rand_len();
		logic [31:0] raw;
		int          r;
		r   = $urandom_range(99);
		raw = $urandom;
		if (r < 8)
			return '0;
		else if (r < 70)
			return 28'($urandom_range(1, 300));
		else if (r < 88)
			return 28'($urandom_range(301, 200000));
		else if (r < 97)
			return raw[27:0];
		return '1;
	endfunction

	function automatic logic [30:0] rand_pos();
		logic [31:0] raw;
		int          r;
		r   = $urandom_range(99);
		raw = $urandom;
		if (r < 5)
			return '0;
		else if (r < 10)
			return '1;
		return raw[30:0];
	endfunction

	// Offer one op transaction, with random idle cycles first. push stays high
	// across back-to-back transactions; full is read as it was before the edge.
	task automatic send_op(input c2ab_pkg::op_item_t it);
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		op   <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		blocks.note_op(it);
		ops_sent++;
	endtask

	task automatic run_directed();
		// zero-length match as a whole read
		send_op(mk_op(c2ab_pkg::OP_M, '0, '0, 1'b0, 1'b1));
		// every op kind but H and P, longest op, farthest position, reverse strand,
		// ending on an unused code that still closes the read
		send_op(mk_op(c2ab_pkg::OP_S, 28'd5, '1, 1'b1, 1'b0));
		send_op(mk_op(c2ab_pkg::OP_M, '1, '1, 1'b1, 1'b0));
		send_op(mk_op(c2ab_pkg::OP_I, 28'd3, '1, 1'b1, 1'b0));
		send_op(mk_op(c2ab_pkg::OP_N, 28'd100, '1, 1'b1, 1'b0));
		send_op(mk_op(c2ab_pkg::OP_D, 28'd7, '1, 1'b1, 1'b0));
		send_op(mk_op(c2ab_pkg::OP_EQ, 28'd20, '1, 1'b1, 1'b0));
		send_op(mk_op(c2ab_pkg::OP_X, 28'd1, '1, 1'b1, 1'b0));
		send_op(mk_op(OP_UNUSED_TOP, 28'd9, '1, 1'b1, 1'b1));
		// skip at read start, skip after skip, final skip inside a block
		send_op(mk_op(c2ab_pkg::OP_N, 28'd50, 31'd1234, 1'b0, 1'b0));
		send_op(mk_op(c2ab_pkg::OP_N, 28'd30, 31'd1234, 1'b0, 1'b0));
		send_op(mk_op(c2ab_pkg::OP_M, 28'd5, 31'd1234, 1'b0, 1'b0));
		send_op(mk_op(c2ab_pkg::OP_N, 28'd10, 31'd1234, 1'b0, 1'b1));
		// ignored final op while a block is only pending
		send_op(mk_op(c2ab_pkg::OP_M, 28'd4, 31'd77, 1'b1, 1'b0));
		send_op(mk_op(c2ab_pkg::OP_N, 28'd6, 31'd77, 1'b1, 1'b0));
		send_op(mk_op(c2ab_pkg::OP_I, 28'd2, 31'd77, 1'b1, 1'b1));
		// read end past 2^32-1 must stick at all ones
		for (int i = 0; i < 9; i++)
			send_op(mk_op(c2ab_pkg::OP_M, '1, '1, 1'b0, i == 8));
	endtask

	// One random read. Plain reads look like real CIGAR strings; noise uses
	// any code and scatters final flags; huge reads drive the sums to saturation.
	task automatic send_read(input int style);
		c2ab_pkg::op_item_t it;
		int                 n_ops;
		int                 r;
		logic [30:0]        pos;
		logic               rev;
		logic [3:0]         kind;
		n_ops = (style == READ_HUGE) ? $urandom_range(33, 36) : $urandom_range(1, 8);
		pos   = rand_pos();
		rev   = 1'($urandom_range(1));
		for (int i = 0; i < n_ops; i++) begin
			r = $urandom_range(99);
			if (style == READ_NOISE) begin
				kind = 4'($urandom_range(15));
			end else if (style == READ_HUGE) begin
				if (i == n_ops - 1 && r < 50)
					kind = c2ab_pkg::OP_N;
				else
					kind = (r < 60) ? c2ab_pkg::OP_M : c2ab_pkg::OP_EQ;
			end else if ((i == 0 || i == n_ops - 1) && n_ops > 2 && r < 25) begin
				kind = (r < 15) ? c2ab_pkg::OP_S : c2ab_pkg::OP_H;
			end else begin
				r = $urandom_range(99);
				if (r < 45)      kind = c2ab_pkg::OP_M;
				else if (r < 55) kind = c2ab_pkg::OP_I;
				else if (r < 65) kind = c2ab_pkg::OP_D;
				else if (r < 78) kind = c2ab_pkg::OP_N;
				else if (r < 86) kind = c2ab_pkg::OP_EQ;
				else if (r < 94) kind = c2ab_pkg::OP_X;
				else             kind = c2ab_pkg::OP_P;
			end
			it.op_kind = kind;
			if (style == READ_HUGE)
				it.op_length = ($urandom_range(1) == 1) ? '1 : 28'($urandom_range(
					28'h800_0000, 28'hFFF_FFFF));
			else
				it.op_length = rand_len();
			it.read_position = (style == READ_NOISE) ? rand_pos() : pos;
			it.reverse_flag  = (style == READ_NOISE) ? 1'($urandom_range(1)) : rev;
			it.final_op      = (i == n_ops - 1) ||
				(style == READ_NOISE && $urandom_range(9) == 0);
			send_op(it);
		end
	endtask

	// Result side: pop idles at random; a result transaction is checked at
	// the edge where pop and a non-empty queue meet.
	initial begin
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				blocks.check_block(blk);
			pop <= ($urandom_range(99) >= gap_pct);
		end
	end

	// Main sequence: reset, directed reads, random reads, drain, verdict.
	initial begin
		int goal;
		int r;
		arst_n <= 1'b0;
		push   <= 1'b0;
		op     <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		goal = ops_sent + RANDOM_OPS;
		while (ops_sent < goal) begin
			// a long run in the middle with no idling on either side
			gap_pct = (ops_sent >= 350 && ops_sent < 550) ? 0 : 16;
			r = $urandom_range(99);
			if (r < 2)
				send_read(READ_HUGE);
			else if (r < 15)
				send_read(READ_NOISE);
			else
				send_read(READ_PLAIN);
		end
		push <= 1'b0;
		gap_pct = 16;

		// the watchdog ends the run if owed blocks never show up
		while (blocks.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (blocks.errors == 0 && blocks.owed.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/c2ab_pkg.sv
rtl/c2ab_front.sv
rtl/c2ab_back.sv
rtl/c2ab_resq.sv
rtl/cigar_to_aligned_blocks_top.sv
dv/tb_top.sv
